FILE: design/cdls_pkg.sv
// Package: shared constants, result codes and queue entry type for the delimiter scanner.
package cdls_pkg;

  // Field widths
  localparam int CHAR_W = 16;
  localparam int POS_W  = 32;

  // Longest delimiter the window can hold
  localparam int MAX_DELIM = 16;
  localparam int DLEN_W    = $clog2(MAX_DELIM + 1);
  localparam int DIDX_W    = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;

  // Character codes
  localparam logic [CHAR_W-1:0] EOF_CODE   = 16'hFFFF;
  localparam logic [CHAR_W-1:0] TERM_RESET = 16'd124;

  // Queue between front and back; depth must be a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_TOKEN = 2'd1,
    KIND_EOF   = 2'd2,
    KIND_LONG  = 2'd3
  } kind_t;

  // One queue entry: the results caused by one input transaction
  typedef struct packed {
    logic              has_data;
    logic              has_tail;
    kind_t             tail_kind;
    logic [CHAR_W-1:0] data_char;
    logic [POS_W-1:0]  tok_start;
    logic [POS_W-1:0]  tok_end;
  } entry_t;

endpackage

FILE: design/cdls_if.sv
// Interfaces: character input channel, result output channel, configuration write channel.
interface cdls_in_if;
  import cdls_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic [POS_W-1:0]  position;
  modport source (output valid, output char_code, output position, input ready);
  modport sink (input valid, input char_code, input position, output ready);
endinterface

interface cdls_out_if;
  import cdls_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [CHAR_W-1:0] char_code_out;
  logic [POS_W-1:0]  token_start;
  logic [POS_W-1:0]  token_end;
  logic              last;
  modport source (output valid, output kind, output char_code_out, output token_start,
                  output token_end, output last, input ready);
  modport sink (input valid, input kind, input char_code_out, input token_start,
                input token_end, input last, output ready);
endinterface

interface cdls_cfg_if;
  import cdls_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] terminator_code;
  modport source (output valid, output terminator_code, input ready);
  modport sink (input valid, input terminator_code, output ready);
endinterface

FILE: design/cdls_front.sv
// Front end: accepts characters, tracks delimiter and window state, queues result entries.
module cdls_front (
  input  logic            clk,
  input  logic            rst,
  cdls_in_if.sink         chars,
  cdls_cfg_if.sink        cfg,
  input  logic            q_full,
  output logic            q_push,
  output cdls_pkg::entry_t q_entry
);
  import cdls_pkg::*;

  // Scanner state
  logic [CHAR_W-1:0] term;
  logic              in_body, in_body_next;
  logic [DLEN_W-1:0] dlen, dlen_next;
  logic [DLEN_W-1:0] bcnt, bcnt_next;
  logic [POS_W-1:0]  start_pos, start_pos_next;
  logic              start_cap, start_cap_next;
  // dchr[k] is the k-th most recent delimiter char; win[k] the k-th most recent body char
  logic [CHAR_W-1:0] dchr [MAX_DELIM];
  logic [CHAR_W-1:0] dchr_next [MAX_DELIM];
  logic [CHAR_W-1:0] win [MAX_DELIM];
  logic [CHAR_W-1:0] win_next [MAX_DELIM];
  logic [CHAR_W-1:0] win_sh [MAX_DELIM];

  logic              accept;
  logic              match_sh, match_zero, rearm;
  logic [DLEN_W-1:0] dlen_m1;
  logic [DIDX_W-1:0] ev_idx;
  logic [POS_W-1:0]  start_eff;

  assign chars.ready = !q_full;
  assign cfg.ready   = 1'b1;
  assign accept      = chars.valid && chars.ready;
  assign start_eff   = start_cap ? start_pos : chars.position;
  assign dlen_m1     = dlen - DLEN_W'(1);
  assign ev_idx      = dlen_m1[DIDX_W-1:0];

  // Shifted window and parallel compares against the delimiter
  always_comb begin
    match_sh   = 1'b1;
    match_zero = 1'b1;
    win_sh[0]  = chars.char_code;
    for (int k = 1; k < MAX_DELIM; k++) begin
      win_sh[k] = win[k-1];
    end
    for (int j = 0; j < MAX_DELIM; j++) begin
      if (DLEN_W'(j) < dlen) begin
        if (win_sh[j] != dchr[j]) match_sh = 1'b0;
        if (dchr[j] != '0) match_zero = 1'b0;
      end
    end
  end

  // Classify the transaction and form next state
  always_comb begin
    in_body_next   = in_body;
    dlen_next      = dlen;
    bcnt_next      = bcnt;
    start_pos_next = start_pos;
    start_cap_next = start_cap;
    dchr_next      = dchr;
    win_next       = win;
    rearm          = 1'b0;
    q_push         = 1'b0;
    q_entry        = '0;
    q_entry.tok_start = start_eff;
    q_entry.tok_end   = chars.position;

    if (accept) begin
      if (!start_cap) begin
        start_pos_next = chars.position;
        start_cap_next = 1'b1;
      end
      if (chars.char_code == EOF_CODE) begin
        q_entry.has_tail  = 1'b1;
        q_entry.tail_kind = KIND_EOF;
        rearm = 1'b1;
      end else if (!in_body) begin
        if (chars.char_code == term) begin
          if (match_zero) begin
            // empty or all-zero delimiter ends the token at once
            q_entry.has_tail  = 1'b1;
            q_entry.tail_kind = KIND_TOKEN;
            rearm = 1'b1;
          end else begin
            in_body_next = 1'b1;
            bcnt_next    = '0;
            for (int k = 0; k < MAX_DELIM; k++) win_next[k] = '0;
          end
        end else if (dlen >= DLEN_W'(MAX_DELIM)) begin
          q_entry.has_tail  = 1'b1;
          q_entry.tail_kind = KIND_LONG;
          rearm = 1'b1;
        end else begin
          dchr_next[0] = chars.char_code;
          for (int k = 1; k < MAX_DELIM; k++) dchr_next[k] = dchr[k-1];
          dlen_next = dlen + DLEN_W'(1);
        end
      end else begin
        // body char: shift window, evict oldest once the window is full
        win_next = win_sh;
        if (bcnt >= dlen) begin
          q_entry.has_data  = 1'b1;
          q_entry.data_char = win[ev_idx];
        end else begin
          bcnt_next = bcnt + DLEN_W'(1);
        end
        if (match_sh) begin
          q_entry.has_tail  = 1'b1;
          q_entry.tail_kind = KIND_TOKEN;
          rearm = 1'b1;
        end
      end
      q_push = q_entry.has_data || q_entry.has_tail;
    end

    if (rearm) begin
      in_body_next   = 1'b0;
      dlen_next      = '0;
      bcnt_next      = '0;
      start_cap_next = 1'b0;
      for (int k = 0; k < MAX_DELIM; k++) win_next[k] = '0;
    end
  end

  // Control state and window
  always_ff @(posedge clk) begin
    if (rst) begin
      term      <= TERM_RESET;
      in_body   <= 1'b0;
      dlen      <= '0;
      bcnt      <= '0;
      start_cap <= 1'b0;
      for (int k = 0; k < MAX_DELIM; k++) win[k] <= '0;
    end else begin
      if (cfg.valid) term <= cfg.terminator_code;
      in_body   <= in_body_next;
      dlen      <= dlen_next;
      bcnt      <= bcnt_next;
      start_cap <= start_cap_next;
      win       <= win_next;
    end
  end

  // Delimiter chars and start position need no reset
  always_ff @(posedge clk) begin
    dchr      <= dchr_next;
    start_pos <= start_pos_next;
  end

endmodule

FILE: design/cdls_fifo.sv
// Short show-ahead queue of result entries between front and back.
module cdls_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cdls_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output cdls_pkg::entry_t head
);
  import cdls_pkg::*;

  entry_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0]   cnt;
  logic                 do_pop;

  assign full       = (cnt == FIFO_CW'(FIFO_DEPTH));
  assign head_valid = (cnt != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (do_pop) rd_ptr <= rd_ptr + FIFO_AW'(1);
      cnt <= cnt + FIFO_CW'(push) - FIFO_CW'(do_pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

endmodule

FILE: design/cdls_back.sv
// Back end: unpacks queue entries into one or two results on the output register.
module cdls_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  cdls_pkg::entry_t head,
  output logic             pop,
  cdls_out_if.source       results
);
  import cdls_pkg::*;

  logic              phase, phase_next;   // data part of head already sent
  logic              load, emit;
  logic [1:0]        kind_next;
  logic [CHAR_W-1:0] char_next;
  logic [POS_W-1:0]  start_next, end_next;
  logic              last_next;

  assign load = !results.valid || results.ready;

  // Pick the next result from the head entry
  always_comb begin
    pop        = 1'b0;
    emit       = 1'b0;
    phase_next = phase;
    kind_next  = KIND_DATA;
    char_next  = '0;
    start_next = '0;
    end_next   = '0;
    last_next  = 1'b1;
    if (load && head_valid) begin
      emit = 1'b1;
      if (head.has_data && !phase) begin
        char_next = head.data_char;
        last_next = !head.has_tail;
        if (head.has_tail) phase_next = 1'b1;
        else pop = 1'b1;
      end else begin
        kind_next = head.tail_kind;
        if (head.tail_kind == KIND_TOKEN) begin
          start_next = head.tok_start;
          end_next   = head.tok_end;
        end
        pop        = 1'b1;
        phase_next = 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      phase         <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) results.valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      results.kind          <= kind_next;
      results.char_code_out <= char_next;
      results.token_start   <= start_next;
      results.token_end     <= end_next;
      results.last          <= last_next;
    end
  end

endmodule

FILE: design/custom_delimiter_literal_scan.sv
// A character's results pass through the queue register and then the output register.
// Throughput: one character per cycle while the queue is not full; a character with two results holds the output
// register for two transactions, and the four-entry queue absorbs the difference until it fills.
// Window match is a parallel compare of all delimiter lanes in the front stage.
// Reset (rst, synchronous): scanner rearmed, window zeroed, terminator back to '|',
// queue and output emptied; no clearing pass.
module custom_delimiter_literal_scan (
  input  logic       clk,
  input  logic       rst,
  cdls_in_if.sink    chars,
  cdls_cfg_if.sink   cfg,
  cdls_out_if.source results
);
  import cdls_pkg::*;

  logic   q_full, q_push, q_pop, q_head_valid;
  entry_t q_entry, q_head;

  // Front: scanner state and classification
  cdls_front u_front (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // Queue between front and back
  cdls_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Back: result serializer
  cdls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .results    (results)
  );

endmodule

FILE: design/cdls_checker.sv
// Checker: port-level assertions for the scanner, bound to the top level.
module cdls_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] char_code_out,
  input logic [31:0] token_start,
  input logic [31:0] token_end,
  input logic        last
);
  import cdls_pkg::*;

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_code_out)
      && $stable(token_start) && $stable(token_end) && $stable(last))
    else $error("result changed while stalled");

  // Only a data char can be followed by another result of the same character
  a_tail_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> last)
    else $error("non-data result without last");

  // Positions are zero except on token end
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_TOKEN |-> token_start == '0 && token_end == '0)
    else $error("positions set on non-token result");

  // Character is zero except on data
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> char_code_out == '0)
    else $error("char set on non-data result");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind custom_delimiter_literal_scan cdls_checker u_cdls_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .kind          (results.kind),
  .char_code_out (results.char_code_out),
  .token_start   (results.token_start),
  .token_end     (results.token_end),
  .last          (results.last)
);

FILE: verif/literal_scan_checker.sv
`timescale 1ns / 1ps
// Scanner checker: follows the scan state from observed transactions, predicts and compares.
module literal_scan_checker (
  input  logic clk,
  input  logic rst,
  cdls_in_if   chars,
  cdls_cfg_if  cfg,
  cdls_out_if  results,
  output int   fail_count,
  output int   pending
);
  import cdls_pkg::*;

  typedef struct {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  tok_start;
    logic [POS_W-1:0]  tok_end;
    logic              last;
  } scan_result_t;

  // Results still owed by the block, oldest first
  scan_result_t expected_results [$];

  // Shadow copy of the scanner
  logic [CHAR_W-1:0] terminator;
  bit                in_body;
  logic [CHAR_W-1:0] delim_chars [MAX_DELIM];
  int                delim_len;
  logic [CHAR_W-1:0] window [MAX_DELIM];
  int                body_cnt;
  logic [POS_W-1:0]  start_pos;
  bit                start_seen;

  function automatic scan_result_t make_result(kind_t k, logic [CHAR_W-1:0] ch,
                                               logic [POS_W-1:0] st, logic [POS_W-1:0] en);
    scan_result_t r;
    r.kind      = k;
    r.ch        = ch;
    r.tok_start = st;
    r.tok_end   = en;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic void clear_window();
    foreach (window[i]) window[i] = '0;
    body_cnt = 0;
  endfunction

  function automatic void rearm_scanner();
    in_body    = 1'b0;
    delim_len  = 0;
    start_seen = 1'b0;
    clear_window();
  endfunction

  // Empty delimiter always matches
  function automatic bit window_hits();
    int i;
    for (i = 0; i < delim_len; i++)
      if (window[i] != delim_chars[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the shadow scanner by one character and queue what it produces
  task automatic scan_char(input logic [CHAR_W-1:0] c, input logic [POS_W-1:0] pos);
    scan_result_t      r [2];
    int                n;
    int                i;
    bit                tok_done;
    logic [CHAR_W-1:0] evicted;
    n        = 0;
    tok_done = 1'b0;
    if (!start_seen) begin
      start_pos  = pos;
      start_seen = 1'b1;
    end
    if (c == EOF_CODE) begin
      // end of input wins over everything, terminator included
      r[n] = make_result(KIND_EOF, '0, '0, '0);
      n++;
      rearm_scanner();
    end else if (!in_body) begin
      if (c == terminator) begin
        in_body = 1'b1;
        clear_window();
        tok_done = window_hits();
      end else if (delim_len >= MAX_DELIM) begin
        r[n] = make_result(KIND_LONG, '0, '0, '0);
        n++;
        rearm_scanner();
      end else begin
        delim_chars[delim_len] = c;
        delim_len++;
      end
    end else begin
      if (delim_len > 0) begin
        evicted = window[0];
        for (i = 0; i + 1 < delim_len; i++) window[i] = window[i + 1];
        window[delim_len - 1] = c;
        // slots still holding the initial zeros are never emitted
        if (body_cnt >= delim_len) begin
          r[n] = make_result(KIND_DATA, evicted, '0, '0);
          n++;
        end else begin
          body_cnt++;
        end
      end
      tok_done = window_hits();
    end
    if (tok_done) begin
      r[n] = make_result(KIND_TOKEN, '0, start_pos, pos);
      n++;
      rearm_scanner();
    end
    for (i = 0; i < n; i++) begin
      r[i].last = (i == n - 1);
      expected_results.insert(expected_results.size(), r[i]);
    end
  endtask

  // Inputs and outputs sampled at the edge, before the block's own updates land
  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      terminator = TERM_RESET;
      start_pos  = '0;
      foreach (delim_chars[i]) delim_chars[i] = '0;
      rearm_scanner();
      expected_results.delete();
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
        terminator = cfg.terminator_code;
      if (chars.valid === 1'b1 && chars.ready === 1'b1)
        scan_char(chars.char_code, chars.position);
      if (results.valid === 1'b1 && results.ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with none pending: kind %0d char %h start %h end %h last %b",
                     $time, results.kind, results.char_code_out, results.token_start,
                     results.token_end, results.last);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (results.kind !== want.kind || results.char_code_out !== want.ch ||
              results.token_start !== want.tok_start || results.token_end !== want.tok_end ||
              results.last !== want.last) begin
            if (fail_count < 10) begin
              $display("%0t: result mismatch: expected kind %0d char %h start %h end %h last %b",
                       $time, want.kind, want.ch, want.tok_start, want.tok_end, want.last);
              $display("%0t:                   got kind %0d char %h start %h end %h last %b",
                       $time, results.kind, results.char_code_out, results.token_start,
                       results.token_end, results.last);
            end
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, character and terminator stimulus, output back-pressure, verdict.
module testbench;
  import cdls_pkg::*;

  localparam int TOTAL_CHARS  = 1300;
  localparam int NUM_PHASES   = 6;
  localparam int STALL_CYCLES = 60;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [CHAR_W-1:0] CH_A = 16'h0061;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   stall_reqs;
  int   stall_served;
  int   sent;

  logic [POS_W-1:0]  next_pos;
  logic [CHAR_W-1:0] term;
  logic [CHAR_W-1:0] phase_terms [NUM_PHASES] =
    '{16'h0000, EOF_CODE, CH_A, 16'hFFFE, TERM_RESET, 16'h1234};

  cdls_in_if  chars_if ();
  cdls_cfg_if cfg_if ();
  cdls_out_if results_if ();

  custom_delimiter_literal_scan dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .cfg     (cfg_if),
    .results (results_if)
  );

  literal_scan_checker scan_check (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars_if),
    .cfg        (cfg_if),
    .results    (results_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Output back-pressure; each new stall request holds ready low for a fixed stretch
  initial begin
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_served != stall_reqs) begin
        stall_served = stall_reqs;
        results_if.ready <= 1'b0;
        repeat (STALL_CYCLES - 1) @(posedge clk);
      end else begin
        results_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Mostly a small alphabet so delimiters recur in the body
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 60) return CHAR_W'(CH_A + $urandom_range(0, 3));
    else if (r < 70) return '0;
    else if (r < 75) return TERM_RESET;
    else return CHAR_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_delim_char();
    logic [CHAR_W-1:0] c;
    do c = pick_char(); while (c == term || c == EOF_CODE);
    return c;
  endfunction

  // One character transaction, then a random gap
  task automatic send_char(input logic [CHAR_W-1:0] c);
    chars_if.valid     <= 1'b1;
    chars_if.char_code <= c;
    chars_if.position  <= next_pos;
    do @(posedge clk); while (chars_if.ready !== 1'b1);
    next_pos++;
    sent++;
    while ($urandom_range(99) < tx_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_terminator(input logic [CHAR_W-1:0] t);
    cfg_if.valid           <= 1'b1;
    cfg_if.terminator_code <= t;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
  endtask

  // Stop sending and let the block drain; delimiter chars owe no result, hence the tail
  task automatic settle();
    chars_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random literal: mostly well formed, some noise, long delimiters and broken bodies
  task automatic send_literal();
    logic [CHAR_W-1:0] delim [MAX_DELIM];
    logic [CHAR_W-1:0] c;
    int                r;
    int                dlen;
    int                blen;
    int                i;
    r = $urandom_range(99);
    if (r < 3) next_pos = $urandom;
    else if (r < 4) next_pos = 32'hFFFF_FFFF - $urandom_range(0, 8);
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(99) < 15) send_char(EOF_CODE);
        else send_char(CHAR_W'($urandom_range(0, 16'hFFFF)));
      end
    end else if (r < 12) begin
      repeat (MAX_DELIM + 1) send_char(pick_delim_char());
    end else begin
      r = $urandom_range(99);
      if (r < 10) dlen = 0;
      else if (r < 85) dlen = $urandom_range(1, 4);
      else dlen = $urandom_range(5, MAX_DELIM);
      for (i = 0; i < dlen; i++) begin
        delim[i] = pick_delim_char();
        send_char(delim[i]);
      end
      send_char(term);
      blen = $urandom_range(0, 8);
      for (i = 0; i < blen; i++) begin
        r = $urandom_range(99);
        if (r < 3) begin
          send_char(EOF_CODE);
          return;
        end else if (r < 55 && dlen > 0) begin
          c = delim[$urandom_range(0, dlen - 1)];
        end else begin
          c = pick_char();
        end
        send_char(c);
      end
      // occasionally leave the literal open
      if ($urandom_range(99) >= 5)
        for (i = 0; i < dlen; i++) send_char(delim[i]);
    end
  endtask

  initial begin
    int ph;
    int i;
    rst                    <= 1'b1;
    chars_if.valid         <= 1'b0;
    chars_if.char_code     <= '0;
    chars_if.position      <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.terminator_code <= '0;
    tx_idle_pct = 9;
    rx_idle_pct = 86;
    stall_reqs  = 0;
    sent        = 0;
    next_pos    = '0;
    term        = TERM_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Delimiter too long: sixteen held, the seventeenth overflows
    for (i = 0; i <= MAX_DELIM; i++)
      send_char(i == 0 ? 16'hFFFE : CHAR_W'(32'd1 << (i - 1)));
    // Empty delimiter ends the token on the terminator, just below the position wrap
    next_pos = 32'hFFFF_FFFE;
    send_char(TERM_RESET);
    // Terminator inside the body, then data and token end from one char, across the position wrap
    send_char(CH_A);
    send_char(TERM_RESET);
    send_char(TERM_RESET);
    send_char(CH_A);
    // Early match while the window still holds initial zeros
    send_char(16'h0000);
    send_char(CH_A);
    send_char(TERM_RESET);
    send_char(CH_A);
    // End of input
    send_char(EOF_CODE);
    settle();

    // Random phases: terminator setting and idling pattern change per phase
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      tx_idle_pct = (ph < 2) ? 9 : (ph < 4) ? 86 : 0;
      rx_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 9 : 0;
      term = phase_terms[ph];
      write_terminator(term);
      stall_reqs++;
      while (sent < (ph + 1) * TOTAL_CHARS / NUM_PHASES) send_literal();
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/cdls_pkg.sv
design/cdls_if.sv
design/cdls_front.sv
design/cdls_fifo.sv
design/cdls_back.sv
design/custom_delimiter_literal_scan.sv
design/cdls_checker.sv
verif/literal_scan_checker.sv
verif/testbench.sv
